// ===== rtl/pqte_pkg.sv =====
// pqte_pkg: shared types, constants and helpers for the piecewise quintic
// trajectory evaluator. No dependencies; imported by every rtl module.

package pqte_pkg;

    // table geometry
    localparam int NUM_LINKS  = 3;
    localparam int NUM_COEFFS = 6;
    localparam int NUM_SEGS   = 2;
    localparam int TBL_DEPTH  = NUM_LINKS * NUM_SEGS * NUM_COEFFS;
    localparam int ADDR_W     = $clog2(TBL_DEPTH);
    localparam int K_W        = $clog2(NUM_COEFFS);

    // field widths
    localparam int LINK_W = 2;
    localparam int POW_W  = 3;
    localparam int COEF_W = 32;
    localparam int T_W    = 20;
    localparam int T_FRAC = 17;

    // accumulator: coefficients grow by at most a factor of eight per power of t
    localparam int ACC_W = COEF_W + 3 * (NUM_COEFFS - 1) + 1;
    // the multiply by t is split into a low unsigned part and a high signed part
    localparam int LO_W  = 24;
    localparam int HI_W  = ACC_W - LO_W;
    localparam int PLO_W = LO_W + T_W + 1;
    localparam int PHI_W = HI_W + T_W + 1;
    localparam int RND_W = PLO_W - T_FRAC;
    localparam int HI_SH = LO_W - T_FRAC;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // configuration register indexes
    localparam logic CFG_FIRST_DUR  = 1'b0;
    localparam logic CFG_SECOND_DUR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_TOP,
        S_INIT,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic           load;
        logic           capture;
        logic           rd_en;
        logic [K_W-1:0] rd_k;
        logic           init_acc;
        logic           mul;
        logic           acc_step;
        logic           emit;
    } t_dp_cmd;

    typedef struct packed {
        logic link_ok;
    } t_dp_status;

    function automatic logic [ADDR_W-1:0] coef_addr(
        input logic [LINK_W-1:0] link,
        input logic              seg,
        input logic [POW_W-1:0]  pw
    );
        int a;
        a = (int'(link) * NUM_SEGS + int'(seg)) * NUM_COEFFS + int'(pw);
        return ADDR_W'(a);
    endfunction

endpackage

// ===== rtl/pqte_ctrl.sv =====
// pqte_ctrl: sequencer for the evaluator; steps the horner loop over the
// coefficient table. Depends on pqte_pkg; drives pqte_datapath by command struct.

module pqte_ctrl import pqte_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_opcode,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy
);

    localparam logic [K_W-1:0] K_TOP = K_W'(NUM_COEFFS - 1);

    t_state         r_state, n_state;
    logic [K_W-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_EVAL) begin
                        o_cmd.capture = 1'b1;
                        n_state = i_status.link_ok ? S_READ_TOP : S_DONE;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_READ_TOP: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_k  = K_TOP;
                n_k         = K_TOP - K_W'(1);
                n_state     = S_INIT;
            end
            S_INIT: begin
                // top coefficient lands in the accumulator, fetch the next one
                o_cmd.init_acc = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_k     = r_k;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_step = 1'b1;
                if (r_k == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_k  = r_k - K_W'(1);
                    n_k         = r_k - K_W'(1);
                    n_state     = S_MUL;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/pqte_datapath.sv =====
// pqte_datapath: coefficient memory, duration registers, segment select,
// split multiply by t with rounding, accumulator and output saturation. Uses pqte_pkg.

module pqte_datapath import pqte_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [T_W-1:0]           i_cfg_data,
    input  logic [LINK_W-1:0]        i_link_index,
    input  logic                     i_segment_select,
    input  logic [POW_W-1:0]         i_power_index,
    input  logic signed [COEF_W-1:0] i_coefficient_value,
    input  logic [T_W-1:0]           i_time_value,
    output logic signed [COEF_W-1:0] o_joint_angle,
    output logic                     o_angle_saturated,
    output logic                     o_valid
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(COEF_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(COEF_MIN);
    localparam logic [PLO_W-1:0]        HALF    = PLO_W'(1) << (T_FRAC - 1);

    logic signed [COEF_W-1:0] r_coef_mem [TBL_DEPTH];
    logic signed [COEF_W-1:0] r_rd_data;

    logic [T_W-1:0]           r_first_dur, r_second_dur;
    logic [T_W-1:0]           r_t;
    logic                     r_seg;
    logic [LINK_W-1:0]        r_link;
    logic signed [ACC_W-1:0]  r_acc;
    logic [RND_W-1:0]         r_lo_rnd;
    logic signed [PHI_W-1:0]  r_p_hi;

    logic                     n_seg;
    logic [T_W-1:0]           n_t;
    logic [T_W:0]             dur_sum;
    logic                     wr_ok;
    logic [PLO_W-1:0]         p_lo;
    logic signed [PHI_W-1:0]  p_hi;
    logic signed [ACC_W-1:0]  hi_term, lo_term, c_term, n_acc;

    assign o_status.link_ok = (32'(i_link_index) < NUM_LINKS);
    assign wr_ok = o_status.link_ok && (32'(i_power_index) < NUM_COEFFS);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_dur  <= '0;
            r_second_dur <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_DUR:  r_first_dur  <= i_cfg_data;
                CFG_SECOND_DUR: r_second_dur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient table
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_coef_mem[coef_addr(i_link_index, i_segment_select, i_power_index)]
                <= i_coefficient_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_coef_mem[coef_addr(r_link, r_seg, POW_W'(i_cmd.rd_k))];
        end
    end

    // segment choice: A up to the first duration, then B, then B held at its end
    assign dur_sum = {1'b0, r_first_dur} + {1'b0, r_second_dur};

    always_comb begin
        if (i_time_value <= r_first_dur) begin
            n_seg = 1'b0;
            n_t   = i_time_value;
        end else if ({1'b0, i_time_value} <= dur_sum) begin
            n_seg = 1'b1;
            n_t   = i_time_value - r_first_dur;
        end else begin
            n_seg = 1'b1;
            n_t   = r_second_dur;
        end
    end

    // acc * t split at bit LO_W; the high part is a whole multiple of 2^T_FRAC
    assign p_lo = PLO_W'(r_acc[LO_W-1:0]) * PLO_W'(r_t) + HALF;
    assign p_hi = PHI_W'(signed'(r_acc[ACC_W-1:LO_W])) * PHI_W'(signed'({1'b0, r_t}));

    assign hi_term = ACC_W'(r_p_hi) <<< HI_SH;
    assign lo_term = ACC_W'(signed'({1'b0, r_lo_rnd}));
    assign c_term  = ACC_W'(r_rd_data);
    assign n_acc   = hi_term + lo_term + c_term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_t    <= n_t;
            r_seg  <= n_seg;
            r_link <= i_link_index;
            r_acc  <= '0;
        end else if (i_cmd.init_acc) begin
            r_acc <= c_term;
        end else if (i_cmd.acc_step) begin
            r_acc <= n_acc;
        end
        if (i_cmd.mul) begin
            r_lo_rnd <= p_lo[PLO_W-1:T_FRAC];
            r_p_hi   <= p_hi;
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_acc > ACC_MAX) begin
                o_joint_angle     <= COEF_MAX;
                o_angle_saturated <= 1'b1;
            end else if (r_acc < ACC_MIN) begin
                o_joint_angle     <= COEF_MIN;
                o_angle_saturated <= 1'b1;
            end else begin
                o_joint_angle     <= r_acc[COEF_W-1:0];
                o_angle_saturated <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/piecewise_quintic_trajectory_eval.sv =====
// piecewise_quintic_trajectory_eval: top level, joins pqte_ctrl and pqte_datapath.
// Depends on pqte_pkg.

// A load beat (opcode 0) writes one coefficient in the accept cycle and busy
// stays low, so loads may follow every cycle. An evaluate beat (opcode 1)
// raises busy for READ_TOP (top coefficient read), INIT (accumulator load
// and next read), a MUL and an ACC step for each remaining coefficient, and
// DONE, set by the registered table read and the split horner step. The
// angle then appears on o_joint_angle/o_angle_saturated for exactly one
// cycle with o_valid high, in the first cycle with busy low; it is not held
// and cannot be stalled. An evaluate of an unused link gives angle 0. The
// user writes durations through i_cfg_we/i_cfg_index/i_cfg_data only while
// busy is low; the block itself does not enforce this.

module piecewise_quintic_trajectory_eval import pqte_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [T_W-1:0]           i_cfg_data,
    input  logic                     i_opcode,
    input  logic [LINK_W-1:0]        i_link_index,
    input  logic                     i_segment_select,
    input  logic [POW_W-1:0]         i_power_index,
    input  logic signed [COEF_W-1:0] i_coefficient_value,
    input  logic [T_W-1:0]           i_time_value,
    output logic                     o_valid,
    output logic signed [COEF_W-1:0] o_joint_angle,
    output logic                     o_angle_saturated
);

    t_dp_cmd    cmd;
    t_dp_status status;

    pqte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pqte_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_link_index        (i_link_index),
        .i_segment_select    (i_segment_select),
        .i_power_index       (i_power_index),
        .i_coefficient_value (i_coefficient_value),
        .i_time_value        (i_time_value),
        .o_joint_angle       (o_joint_angle),
        .o_angle_saturated   (o_angle_saturated),
        .o_valid             (o_valid)
    );

endmodule

// ===== rtl/pqte_checker.sv =====
// pqte_port_props: port-level assertions for piecewise_quintic_trajectory_eval,
// bound to the top level below. Depends on pqte_pkg.

module pqte_port_props import pqte_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     i_opcode,
    input logic                     o_valid,
    input logic signed [COEF_W-1:0] o_joint_angle,
    input logic                     o_angle_saturated
);

    // a result beat is a single-cycle strobe
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("o_valid high for more than one cycle");

    // an accepted evaluate keeps the block busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_EVAL) |=> busy)
        else $error("evaluate accepted without busy");

    // a load produces no result and does not occupy the block
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_LOAD) |=> !busy && !o_valid)
        else $error("load caused busy or a result");

    // a result follows the end of a busy period
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result outside an evaluate");

    // a clipped angle sits on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_angle_saturated |->
            (o_joint_angle == COEF_MAX) || (o_joint_angle == COEF_MIN))
        else $error("saturated angle not at a limit");

endmodule

bind piecewise_quintic_trajectory_eval pqte_port_props u_pqte_port_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_opcode          (i_opcode),
    .o_valid           (o_valid),
    .o_joint_angle     (o_joint_angle),
    .o_angle_saturated (o_angle_saturated)
);
